// ===== rtl/spca_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spca_pkg: shared types and constants of the position code adder
// Holds the frequency table builder, the CORDIC constants and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package spca_pkg;

    // field widths
    localparam int SAMPLE_W = 24;
    localparam int WIDTH_W  = 10;
    localparam int FREQ_W   = 48;
    localparam int ANGLE_W  = 24;
    localparam int CORDIC_W = 34;
    localparam int CODE_W   = 18;
    localparam int ATAN_N   = 24;
    localparam int ATAN_IDX_W = 5;

    // defaults for the top-level parameters
    localparam int DEF_MAX_FEATURE_WIDTH = 560;
    localparam int DEF_POSITION_BITS     = 20;
    localparam int DEF_CORDIC_STAGES     = 18;

    // reset value of the width register
    localparam logic [WIDTH_W-1:0] FEATURE_WIDTH_RESET = 10'd560;

    // frequency table, sized for the largest frame allowed
    localparam int FREQ_DEPTH_MAX = 513;
    localparam logic [FREQ_W-1:0] FREQ_G0    = 48'd44798133900177;
    localparam logic [FREQ_W-1:0] FREQ_RATIO = 48'd272334632980239;

    typedef logic [FREQ_DEPTH_MAX-1:0][FREQ_W-1:0] t_freq_table;

    // g_i = g_(i-1) * ratio in Q0.48, truncated via 24-bit partial products
    function automatic t_freq_table build_freq_table();
        t_freq_table tab;
        logic [63:0] prev;
        logic [63:0] ah;
        logic [63:0] al;
        logic [63:0] bh;
        logic [63:0] bl;
        logic [63:0] mid;
        logic [63:0] low;
        logic [63:0] res;
        tab    = '0;
        tab[0] = FREQ_G0;
        bh     = {16'd0, FREQ_RATIO} >> 24;
        bl     = {16'd0, FREQ_RATIO} & 64'hFF_FFFF;
        for (int i = 1; i < FREQ_DEPTH_MAX; i++) begin
            prev   = {16'd0, tab[i-1]};
            ah     = prev >> 24;
            al     = prev & 64'hFF_FFFF;
            mid    = ah * bl + al * bh;
            low    = al * bl;
            res    = ah * bh + ((mid + (low >> 24)) >> 24);
            tab[i] = res[FREQ_W-1:0];
        end
        return tab;
    endfunction

    localparam t_freq_table FREQ_TABLE = build_freq_table();

    // cordic constants: gain in Q2.30, atan(2^-k) in Q0.32 turns
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032875;

    localparam logic [31:0] ATAN_TURNS [ATAN_N] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic rom_read;
        logic mul_lo;
        logic mul_hi;
        logic rotate;
        logic code;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic rot_last;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== rtl/spca_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spca_ctrl: sequencer of the position code adder
// Steps one item through table read, angle multiply, CORDIC rotations and
// code formation, and owns the handshakes and the output valid flag.
// ----------------------------------------------------------------------------
module spca_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output spca_pkg::t_dp_cmd         o_cmd,
    input  wire spca_pkg::t_dp_status i_status
);
    import spca_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_LOOKUP  = 7'b0000010,
        ST_MUL_LO  = 7'b0000100,
        ST_MUL_HI  = 7'b0001000,
        ST_ROTATE  = 7'b0010000,
        ST_CODE    = 7'b0100000,
        ST_DELIVER = 7'b1000000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd w_cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    w_cmd.accept = 1'b1;
                    n_state      = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                w_cmd.rom_read = 1'b1;
                n_state        = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                w_cmd.mul_lo = 1'b1;
                n_state      = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                w_cmd.mul_hi = 1'b1;
                n_state      = ST_ROTATE;
            end
            ST_ROTATE: begin
                w_cmd.rotate = 1'b1;
                if (i_status.rot_last) begin
                    n_state = ST_CODE;
                end
            end
            ST_CODE: begin
                w_cmd.code = 1'b1;
                n_state    = ST_DELIVER;
            end
            ST_DELIVER: begin
                // wait until the output register is free or being drained
                if (!r_out_valid || i_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb begin
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = w_cmd;

endmodule
`default_nettype wire

// ===== rtl/spca_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spca_dp: datapath of the position code adder
// Frame and element counters, frequency ROM, shared angle multiplier,
// iterative CORDIC, quadrant fold and saturating add into the output register.
// ----------------------------------------------------------------------------
module spca_dp #(
    parameter int MAX_FEATURE_WIDTH = spca_pkg::DEF_MAX_FEATURE_WIDTH,
    parameter int POSITION_BITS     = spca_pkg::DEF_POSITION_BITS,
    parameter int CORDIC_STAGES     = spca_pkg::DEF_CORDIC_STAGES
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [spca_pkg::WIDTH_W-1:0]         i_cfg_wdata,
    input  wire logic signed [spca_pkg::SAMPLE_W-1:0] i_sample_in,
    input  wire logic                                 i_restart,
    input  wire spca_pkg::t_dp_cmd                    i_cmd,
    output spca_pkg::t_dp_status                      o_status,
    output logic signed [spca_pkg::SAMPLE_W-1:0]      o_sample_out,
    output logic                                      o_frame_end,
    output logic                                      o_position_full
);
    import spca_pkg::*;

    localparam int ROM_DEPTH = MAX_FEATURE_WIDTH / 2 + 1;
    localparam int FI_W      = $clog2(ROM_DEPTH);
    localparam int PB        = POSITION_BITS;
    localparam int PROD_W    = ANGLE_W + PB + 1;
    localparam int K_W       = $clog2(CORDIC_STAGES);
    localparam int SUM_W     = SAMPLE_W + 1;

    localparam logic [WIDTH_W:0]   MAX_W     = (WIDTH_W+1)'(MAX_FEATURE_WIDTH);
    localparam logic [WIDTH_W:0]   MIN_W     = (WIDTH_W+1)'(2);
    localparam logic [WIDTH_W-1:0] FI_LIMIT  = WIDTH_W'(ROM_DEPTH - 1);
    localparam logic [K_W-1:0]     K_LAST    = K_W'(CORDIC_STAGES - 1);
    localparam logic [1:0]         QUAD_0    = 2'd0;
    localparam logic [1:0]         QUAD_1    = 2'd1;
    localparam logic [1:0]         QUAD_2    = 2'd2;
    localparam logic [1:0]         QUAD_3    = 2'd3;

    localparam logic [ROM_DEPTH-1:0][FREQ_W-1:0] FREQ_ROM = FREQ_TABLE[ROM_DEPTH-1:0];

    localparam logic signed [CORDIC_W-1:0] ROUND_HALF = CORDIC_W'(16384);
    localparam logic signed [SUM_W-1:0]    SUM_MAX    = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0]    SUM_MIN    = -SUM_W'(8388608);

    // configuration and frame state
    logic [WIDTH_W-1:0] r_feature_width;
    logic [WIDTH_W-1:0] r_elem_idx;
    logic [PB-1:0]      r_pos;

    // per-item registers
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_use_cos;
    logic                       r_frame_end;
    logic                       r_pos_full;
    logic [FI_W-1:0]            r_fi;
    logic [PB:0]                r_pos1;
    logic [FREQ_W-1:0]          r_freq;
    logic [FREQ_W-1:0]          r_acc;

    // cordic registers
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [CORDIC_W-1:0] r_z;
    logic [1:0]                 r_quad;
    logic [K_W-1:0]             r_k;
    logic signed [CODE_W-1:0]   r_code;

    // output register
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_frame_end;
    logic                       r_out_pos_full;

    // element decode
    logic [WIDTH_W:0]   w_clamp;
    logic [WIDTH_W:0]   w_even;
    logic [WIDTH_W:0]   w_eff;
    logic [WIDTH_W-1:0] w_d;
    logic [WIDTH_W-1:0] w_d_m1;
    logic [WIDTH_W-1:0] w_half;
    logic [WIDTH_W-1:0] w_cur_idx;
    logic [PB-1:0]      w_cur_pos;
    logic [WIDTH_W-1:0] w_idx;
    logic               w_frame_end;
    logic               w_use_cos;
    logic [WIDTH_W-1:0] w_fi_raw;
    logic [WIDTH_W-1:0] w_fi;
    logic               w_pos_full;

    always_comb begin
        w_clamp     = ({1'b0, r_feature_width} > MAX_W) ? MAX_W : {1'b0, r_feature_width};
        w_even      = {w_clamp[WIDTH_W:1], 1'b0};
        w_eff       = (w_even < MIN_W) ? MIN_W : w_even;
        w_d         = w_eff[WIDTH_W-1:0];
        w_d_m1      = w_d - 1'b1;
        w_half      = w_d >> 1;
        w_cur_idx   = i_restart ? '0 : r_elem_idx;
        w_cur_pos   = i_restart ? '0 : r_pos;
        w_idx       = (w_cur_idx > w_d_m1) ? w_d_m1 : w_cur_idx;
        w_frame_end = (w_idx == w_d_m1);
        w_use_cos   = (w_idx >= w_half);
        w_fi_raw    = w_use_cos ? (w_idx - w_half) : w_idx;
        w_fi        = (w_fi_raw > FI_LIMIT) ? FI_LIMIT : w_fi_raw;
        w_pos_full  = (w_cur_pos == {PB{1'b1}});
    end

    // width register and frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature_width <= FEATURE_WIDTH_RESET;
            r_elem_idx      <= '0;
            r_pos           <= '0;
        end else begin
            if (i_cfg_we) begin
                r_feature_width <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                if (w_frame_end) begin
                    r_elem_idx <= '0;
                    r_pos      <= w_pos_full ? w_cur_pos : (w_cur_pos + 1'b1);
                end else begin
                    r_elem_idx <= w_idx + 1'b1;
                    r_pos      <= w_cur_pos;
                end
            end
        end
    end

    // capture of the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample    <= i_sample_in;
            r_use_cos   <= w_use_cos;
            r_frame_end <= w_frame_end;
            r_pos_full  <= w_pos_full;
            r_fi        <= w_fi[FI_W-1:0];
            r_pos1      <= {1'b0, w_cur_pos} + 1'b1;
        end
    end

    // frequency rom, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rom_read) begin
            r_freq <= FREQ_ROM[r_fi];
        end
    end

    // shared multiplier: low half then high half of the frequency word
    logic [ANGLE_W-1:0]    w_mul_a;
    logic [PROD_W-1:0]     w_prod;
    logic [PROD_W+47:0]    w_prod_ext;
    logic [FREQ_W-1:0]     w_angle_sum;
    logic [ANGLE_W-1:0]    w_angle;

    assign w_mul_a     = i_cmd.mul_lo ? r_freq[ANGLE_W-1:0] : r_freq[FREQ_W-1:ANGLE_W];
    assign w_prod      = PROD_W'(w_mul_a) * PROD_W'(r_pos1);
    assign w_prod_ext  = {48'd0, w_prod};
    assign w_angle_sum = r_acc + {w_prod_ext[ANGLE_W-1:0], 24'd0};
    assign w_angle     = w_angle_sum[FREQ_W-1:ANGLE_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo) begin
            r_acc <= w_prod_ext[FREQ_W-1:0];
        end
    end

    // cordic micro-rotation
    logic signed [CORDIC_W-1:0] w_dx;
    logic signed [CORDIC_W-1:0] w_dy;
    logic signed [CORDIC_W-1:0] w_atan;

    assign w_dx   = r_y >>> r_k;
    assign w_dy   = r_x >>> r_k;
    assign w_atan = $signed({{(CORDIC_W-32){1'b0}}, ATAN_TURNS[ATAN_IDX_W'(r_k)]});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_hi) begin
            // angle within its quadrant, widened to q0.32 turns
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= $signed({{(CORDIC_W-30){1'b0}}, w_angle[ANGLE_W-3:0], 8'd0});
            r_quad <= w_angle[ANGLE_W-1:ANGLE_W-2];
            r_k    <= '0;
        end else if (i_cmd.rotate) begin
            if (!r_z[CORDIC_W-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
            r_k <= r_k + 1'b1;
        end
    end

    assign o_status.rot_last = (r_k == K_LAST);

    // round to q.15 and fold by quadrant
    logic signed [CORDIC_W-1:0] w_x_rnd;
    logic signed [CORDIC_W-1:0] w_y_rnd;
    logic signed [CODE_W-1:0]   w_c;
    logic signed [CODE_W-1:0]   w_s;
    logic signed [CODE_W-1:0]   w_cq;
    logic signed [CODE_W-1:0]   w_sq;

    assign w_x_rnd = (r_x + ROUND_HALF) >>> 15;
    assign w_y_rnd = (r_y + ROUND_HALF) >>> 15;
    assign w_c     = w_x_rnd[CODE_W-1:0];
    assign w_s     = w_y_rnd[CODE_W-1:0];

    always_comb begin
        unique case (r_quad)
            QUAD_0: begin
                w_cq = w_c;
                w_sq = w_s;
            end
            QUAD_1: begin
                w_cq = -w_s;
                w_sq = w_c;
            end
            QUAD_2: begin
                w_cq = -w_c;
                w_sq = -w_s;
            end
            QUAD_3: begin
                w_cq = w_s;
                w_sq = -w_c;
            end
            default: begin
                w_cq = w_c;
                w_sq = w_s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.code) begin
            r_code <= r_use_cos ? w_cq : w_sq;
        end
    end

    // saturating add into the output register
    logic signed [SUM_W-1:0] w_sum;

    assign w_sum = SUM_W'(r_sample) + SUM_W'(r_code);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (w_sum > SUM_MAX) begin
                r_out_sample <= SUM_MAX[SAMPLE_W-1:0];
            end else if (w_sum < SUM_MIN) begin
                r_out_sample <= SUM_MIN[SAMPLE_W-1:0];
            end else begin
                r_out_sample <= w_sum[SAMPLE_W-1:0];
            end
            r_out_frame_end <= r_frame_end;
            r_out_pos_full  <= r_pos_full;
        end
    end

    assign o_sample_out    = r_out_sample;
    assign o_frame_end     = r_out_frame_end;
    assign o_position_full = r_out_pos_full;

endmodule
`default_nettype wire

// ===== rtl/sinusoidal_position_code_adder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sinusoidal_position_code_adder: adds a sinusoidal position code to features
// Each item is taken, read from the ROM, passed twice through the shared angle
// multiplier, rotated once per CORDIC stage, rounded and folded into a code,
// and loaded into the output once the output register is free. The next item
// is taken while a finished result still waits in the output register. The
// frame width register may be written only while the block is idle; no
// clearing pass follows reset.
// ----------------------------------------------------------------------------
module sinusoidal_position_code_adder #(
    parameter int MAX_FEATURE_WIDTH = spca_pkg::DEF_MAX_FEATURE_WIDTH,
    parameter int POSITION_BITS     = spca_pkg::DEF_POSITION_BITS,
    parameter int CORDIC_STAGES     = spca_pkg::DEF_CORDIC_STAGES
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [spca_pkg::WIDTH_W-1:0]         i_cfg_wdata,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [spca_pkg::SAMPLE_W-1:0] i_sample_in,
    input  wire logic                                 i_restart,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic signed [spca_pkg::SAMPLE_W-1:0]      o_sample_out,
    output logic                                      o_frame_end,
    output logic                                      o_position_full
);
    import spca_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencer
    spca_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    // datapath
    spca_dp #(
        .MAX_FEATURE_WIDTH (MAX_FEATURE_WIDTH),
        .POSITION_BITS     (POSITION_BITS),
        .CORDIC_STAGES     (CORDIC_STAGES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_sample_in     (i_sample_in),
        .i_restart       (i_restart),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_sample_out    (o_sample_out),
        .o_frame_end     (o_frame_end),
        .o_position_full (o_position_full)
    );

`ifndef SYNTH
    // at most one datapath command per cycle
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command active");

    // a transfer in is followed by the rom read
    a_accept_then_rom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accept |=> w_cmd.rom_read)
        else $error("rom read did not follow an input transfer");

    // no second item taken straight after a transfer in
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input still ready right after a transfer");

    // loading the output register always presents a result
    a_load_gives_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_valid)
        else $error("output load did not raise valid");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_sinusoidal_position_code_adder.sv =====
// ----------------------------------------------------------------------------
// tb_sinusoidal_position_code_adder: self-checking bench for the code adder
// Runs a short directed table (saturation at both rails, frame width extremes,
// width lowered mid-frame, restart mid-frame), then random samples in phases
// with different idle and stall patterns. Results are checked against a local
// fixed-point model of the frequency table, angle and CORDIC, or a checked row.
// ----------------------------------------------------------------------------
module tb_sinusoidal_position_code_adder;
    import spca_pkg::*;

    localparam int MAX_WIDTH      = DEF_MAX_FEATURE_WIDTH;
    localparam int POS_W          = DEF_POSITION_BITS;
    localparam int STAGES         = DEF_CORDIC_STAGES;
    localparam int ROM_DEPTH      = MAX_WIDTH / 2 + 1;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [POS_W-1:0]           POS_MAX    = '1;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
    localparam longint                     GAIN_Q30   = 652032875;

    // quadrant of the angle in turns
    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;

    // atan(2^-k) in Q0.32 turns
    localparam longint ATAN_Q32 [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // random phases: idle and stall percentages, sizes
    localparam int PHASE_N = 5;
    localparam int PHASE_SEND_IDLE  [PHASE_N] = '{0, 67, 0, 23, 23};
    localparam int PHASE_RECV_STALL [PHASE_N] = '{0, 0, 67, 23, 23};
    localparam int PHASE_WIDTH      [PHASE_N] = '{2, 14, 200, 0, 560};
    localparam int PHASE_ITEMS      [PHASE_N] = '{70, 70, 70, 70, 300};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_end;
        logic                       position_full;
    } t_code_result;

    typedef enum logic {ROW_SAMPLE, ROW_WIDTH} t_row_kind;

    typedef struct packed {
        t_row_kind                  kind;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       restart;
        logic [WIDTH_W-1:0]         width;
        logic                       typed;
        logic signed [SAMPLE_W-1:0] want_sample;
        logic                       want_end;
    } t_stim_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [WIDTH_W-1:0]         i_cfg_wdata = '0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic                       i_restart = 1'b0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       o_frame_end;
    logic                       o_position_full;

    // model state
    logic [FREQ_W-1:0]  freq_rom [ROM_DEPTH];
    logic [WIDTH_W-1:0] width_reg;
    logic [POS_W-1:0]   frame_pos;
    int unsigned        elem_idx;

    t_code_result sum_q [$];
    int           send_idle = 0;
    int           recv_stall = 0;
    int           mismatches = 0;
    int           results_seen = 0;
    int           quiet_cycles = 0;
    bit           tx_open = 1'b0;

    always #5 i_clk = ~i_clk;

    sinusoidal_position_code_adder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_in    (i_sample_in),
        .i_restart      (i_restart),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample_out   (o_sample_out),
        .o_frame_end    (o_frame_end),
        .o_position_full(o_position_full)
    );

    // rotation from angle in Q0.32 turns to cosine and sine in Q.15
    function automatic void cordic_sincos(input logic [31:0] turn, output int cos_q,
                                          output int sin_q);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        int     c;
        int     s;
        x = GAIN_Q30;
        y = 0;
        z = longint'({2'b00, turn[29:0]});
        for (int k = 0; k < STAGES; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ATAN_Q32[k];
            end else begin
                x += dx;
                y -= dy;
                z += ATAN_Q32[k];
            end
        end
        // round half up to Q.15
        c = int'((x + 64'sd16384) >>> 15);
        s = int'((y + 64'sd16384) >>> 15);
        case (turn[31:30])
            QUAD_FIRST: begin
                cos_q = c;
                sin_q = s;
            end
            QUAD_SECOND: begin
                cos_q = -s;
                sin_q = c;
            end
            QUAD_THIRD: begin
                cos_q = -c;
                sin_q = -s;
            end
            default: begin
                cos_q = s;
                sin_q = -c;
            end
        endcase
    endfunction

    // sample plus position code for one element; advances the frame counters
    function automatic t_code_result add_position_code(input logic signed [SAMPLE_W-1:0] smp,
                                                       input logic rst_flag);
        int unsigned  d;
        int unsigned  half;
        int unsigned  idx;
        int unsigned  fi;
        logic         use_cos;
        logic         last;
        logic [63:0]  prod;
        int           c;
        int           s;
        int           total;
        t_code_result r;
        if (rst_flag) begin
            frame_pos = '0;
            elem_idx  = 0;
        end
        // effective width: clamp, round down to even, at least two
        d = width_reg;
        if (d > MAX_WIDTH) d = MAX_WIDTH;
        d = d & ~32'd1;
        if (d < 2) d = 2;
        half = d / 2;
        // an index beyond a lowered width ends the frame
        idx     = (elem_idx > d - 1) ? d - 1 : elem_idx;
        last    = (idx == d - 1);
        use_cos = (idx >= half);
        fi      = use_cos ? idx - half : idx;
        if (fi >= ROM_DEPTH) fi = ROM_DEPTH - 1;
        // angle keeps the top 24 fraction bits, widened to 32
        prod = {16'd0, freq_rom[fi]} * (64'(frame_pos) + 64'd1);
        cordic_sincos({prod[47:24], 8'd0}, c, s);
        total = int'(smp) + (use_cos ? c : s);
        if (total > int'(SAMPLE_MAX)) total = int'(SAMPLE_MAX);
        if (total < int'(SAMPLE_MIN)) total = int'(SAMPLE_MIN);
        r.sample        = total[SAMPLE_W-1:0];
        r.frame_end     = last;
        r.position_full = (frame_pos == POS_MAX);
        if (last) begin
            elem_idx = 0;
            if (frame_pos != POS_MAX) frame_pos = frame_pos + 1'b1;
        end else begin
            elem_idx = idx + 1;
        end
        return r;
    endfunction

    function automatic t_stim_row sample_row(input logic signed [SAMPLE_W-1:0] s,
                                             input logic r);
        return '{ROW_SAMPLE, s, r, '0, 1'b0, '0, 1'b0};
    endfunction

    function automatic t_stim_row checked_row(input logic signed [SAMPLE_W-1:0] s,
                                              input logic r,
                                              input logic signed [SAMPLE_W-1:0] ws,
                                              input logic we);
        return '{ROW_SAMPLE, s, r, '0, 1'b1, ws, we};
    endfunction

    function automatic t_stim_row width_row(input logic [WIDTH_W-1:0] w);
        return '{ROW_WIDTH, '0, 1'b0, w, 1'b0, '0, 1'b0};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
    endtask

    // drop valid in the step of the last transfer when no sample follows at once
    task automatic release_input();
        if (tx_open) i_valid <= 1'b0;
        tx_open = 1'b0;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic rst_flag,
                               input bit typed, input t_code_result want);
        t_code_result r;
        if ($urandom_range(99) < send_idle) begin
            release_input();
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_valid     <= 1'b1;
        i_sample_in <= smp;
        i_restart   <= rst_flag;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tx_open = 1'b1;
        r = add_position_code(smp, rst_flag);
        sum_q.push_back(typed ? want : r);
    endtask

    task automatic drain_results();
        release_input();
        while (sum_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [WIDTH_W-1:0] w);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        width_reg = w;
    endtask

    // receiver: random stalls, result check and watchdog
    always @(posedge i_clk) begin
        t_code_result want;
        i_ready <= ($urandom_range(99) >= recv_stall);
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (sum_q.size() == 0) begin
                    report_mismatch("unexpected result, sample", o_sample_out, 0);
                end else begin
                    want = sum_q.pop_front();
                    if (o_sample_out !== want.sample)
                        report_mismatch("sample_out", o_sample_out, want.sample);
                    if (o_frame_end !== want.frame_end)
                        report_mismatch("frame_end", o_frame_end, want.frame_end);
                    if (o_position_full !== want.position_full)
                        report_mismatch("position_full", o_position_full, want.position_full);
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("tb_sinusoidal_position_code_adder NOT OK");
                    $finish;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_stim_row                  dir_table [$];
        logic [63:0]                ah;
        logic [63:0]                al;
        logic [63:0]                bh;
        logic [63:0]                bl;
        logic [63:0]                mid;
        logic [63:0]                low;
        logic [63:0]                prod;
        logic signed [SAMPLE_W-1:0] smp;
        logic                       rst_flag;
        logic [WIDTH_W-1:0]         w;

        // frequency table in Q0.48, each entry the previous times the ratio
        freq_rom[0] = FREQ_G0;
        bh = 64'(FREQ_RATIO >> 24);
        bl = 64'(FREQ_RATIO[23:0]);
        for (int i = 1; i < ROM_DEPTH; i++) begin
            ah   = 64'(freq_rom[i-1] >> 24);
            al   = 64'(freq_rom[i-1][23:0]);
            mid  = ah * bl + al * bh;
            low  = al * bl;
            prod = ah * bh + ((mid + (low >> 24)) >> 24);
            freq_rom[i] = prod[FREQ_W-1:0];
        end
        width_reg = FEATURE_WIDTH_RESET;
        frame_pos = '0;
        elem_idx  = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: sin(1) and sin(3) are positive, cos(2) is negative
        dir_table = '{
            checked_row(SAMPLE_MAX, 1'b1, SAMPLE_MAX, 1'b0),
            sample_row(24'sd0, 1'b0),
            sample_row(SAMPLE_MIN, 1'b0),
            sample_row(-24'sd1, 1'b0),
            // width lowered mid-frame: next element closes the frame
            width_row(10'd2),
            sample_row(24'sh123456, 1'b0),
            sample_row(24'sd0, 1'b1),
            sample_row(24'sd0, 1'b0),
            sample_row(24'sd0, 1'b0),
            checked_row(SAMPLE_MIN, 1'b0, SAMPLE_MIN, 1'b1),
            width_row(10'd6),
            checked_row(SAMPLE_MAX, 1'b0, SAMPLE_MAX, 1'b0),
            sample_row(24'sh7FFF00, 1'b0),
            // restart in the middle of a frame
            sample_row(24'sd0, 1'b1),
            width_row(10'd0),
            sample_row(24'sd0, 1'b0),
            width_row(10'd1),
            sample_row(24'sd1, 1'b0),
            width_row(10'd3),
            sample_row(-24'sd1, 1'b0),
            width_row(10'd561),
            sample_row(24'sh555555, 1'b1),
            sample_row(24'shAAAAAA, 1'b0),
            width_row(10'd1023),
            sample_row(24'sd0, 1'b0),
            width_row(10'd560),
            sample_row(24'sd32768, 1'b0)
        };
        foreach (dir_table[n]) begin
            if (dir_table[n].kind == ROW_WIDTH)
                write_width(dir_table[n].width);
            else
                send_sample(dir_table[n].sample, dir_table[n].restart, dir_table[n].typed,
                            {dir_table[n].want_sample, dir_table[n].want_end, 1'b0});
        end

        // random phases; the last one runs more than half a full-width frame so
        // the sine half reaches the far end of the frequency table. the position
        // counter never gets near saturation in a run of this length.
        for (int p = 0; p < PHASE_N; p++) begin
            w = (p == 3) ? WIDTH_W'($urandom_range(63)) : WIDTH_W'(PHASE_WIDTH[p]);
            write_width(w);
            send_idle  = PHASE_SEND_IDLE[p];
            recv_stall = PHASE_RECV_STALL[p];
            for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
                // hold off until the pipeline is empty once
                if (p == 1 && n == PHASE_ITEMS[p] / 2) drain_results();
                case ($urandom_range(15))
                    0:       smp = SAMPLE_MAX;
                    1:       smp = SAMPLE_MIN;
                    default: smp = SAMPLE_W'($urandom);
                endcase
                if (p == PHASE_N - 1)
                    rst_flag = (n == 0);
                else
                    rst_flag = ($urandom_range(63) == 0);
                send_sample(smp, rst_flag, 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_sinusoidal_position_code_adder OK");
        else
            $display("tb_sinusoidal_position_code_adder NOT OK");
        $finish;
    end

endmodule
